// File: sv/crc8lfc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the length-framed checker.
// No dependencies; the files that use it refer to it by scoped names.
package crc8lfc_pkg;

    localparam logic [7:0]  CRC_POLY      = 8'h31;
    localparam logic [15:0] MAX_LEN_RESET = 16'd2370;

    typedef enum logic [1:0] {
        VERDICT_OK   = 2'd0,
        VERDICT_CRC  = 2'd1,
        VERDICT_LONG = 2'd2
    } t_verdict;

    // Verdict request from the frame logic to the output stage
    typedef struct packed {
        logic     has_result;
        t_verdict code;
    } t_result;

    // MSB-first CRC-8, one data bit per step
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/crc8lfc_in_reg.sv
// Input register stage of the CRC-8 length-framed checker.
// Holds one byte request until the frame logic consumes it; no package use.
module crc8lfc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_start,
    input  logic       i_consume,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_start
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_start;

    // Free when empty or when the held request leaves this cycle
    assign o_ready = !r_valid || i_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data  <= i_data;
            r_start <= i_start;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_start = r_start;

endmodule

// File: sv/crc8lfc_frame_ctrl.sv
// Frame tracking, length check and CRC-8 compare for the length-framed checker.
// Uses crc8lfc_pkg for the CRC update and the verdict types.
module crc8lfc_frame_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_data,
    input  logic                 i_start,
    input  logic                 i_step,
    input  logic [15:0]          i_max_len,
    output crc8lfc_pkg::t_result o_result
);

    logic        r_active,    n_active;
    logic [15:0] r_index,     n_index;
    logic [15:0] r_length,    n_length;
    logic [7:0]  r_crc,       n_crc;
    logic [7:0]  r_crc_first, n_crc_first;
    logic [7:0]  r_crc_second, n_crc_second;
    logic [7:0]  r_byte0,     n_byte0;
    logic [7:0]  r_byte1,     n_byte1;

    logic [7:0]  crc_in;
    logic [7:0]  crc_out;
    logic [15:0] len_field;

    assign len_field = {r_byte1, i_data};

    // One CRC unit serves every byte; its seed depends on the byte position
    always_comb begin
        if (i_start) begin
            crc_in = 8'd0;
        end else if (r_index == 16'd1) begin
            crc_in = r_crc_first;
        end else if (r_index == 16'd2) begin
            crc_in = r_crc_second;
        end else begin
            crc_in = r_crc;
        end
    end

    assign crc_out = crc8lfc_pkg::crc8_update(crc_in, i_data);

    always_comb begin
        n_active     = r_active;
        n_index      = r_index;
        n_length     = r_length;
        n_crc        = r_crc;
        n_crc_first  = r_crc_first;
        n_crc_second = r_crc_second;
        n_byte0      = r_byte0;
        n_byte1      = r_byte1;
        o_result.has_result = 1'b0;
        o_result.code       = crc8lfc_pkg::VERDICT_OK;

        if (i_valid) begin
            if (i_start) begin
                // A start mid-frame drops the old frame silently
                n_byte0     = i_data;
                n_crc_first = crc_out;
                n_crc       = crc_out;
                n_index     = 16'd1;
                n_length    = 16'd0;
                n_active    = 1'b1;
            end else if (r_active) begin
                if (r_index == 16'd1) begin
                    n_byte1      = i_data;
                    n_crc_second = crc_out;
                    n_crc        = crc_out;
                    n_index      = 16'd2;
                end else if (r_index == 16'd2) begin
                    n_length = len_field;
                    if (len_field > i_max_len) begin
                        o_result.has_result = 1'b1;
                        o_result.code       = crc8lfc_pkg::VERDICT_LONG;
                    end else if (len_field == 16'd0) begin
                        o_result.has_result = 1'b1;
                        o_result.code = (r_byte0 == 8'd0) ? crc8lfc_pkg::VERDICT_OK
                                                          : crc8lfc_pkg::VERDICT_CRC;
                    end else if (len_field == 16'd1) begin
                        o_result.has_result = 1'b1;
                        o_result.code = (r_byte1 == r_crc_first) ? crc8lfc_pkg::VERDICT_OK
                                                                 : crc8lfc_pkg::VERDICT_CRC;
                    end else if (len_field == 16'd2) begin
                        o_result.has_result = 1'b1;
                        o_result.code = (i_data == r_crc_second) ? crc8lfc_pkg::VERDICT_OK
                                                                 : crc8lfc_pkg::VERDICT_CRC;
                    end else begin
                        n_crc   = crc_out;
                        n_index = 16'd3;
                    end
                end else if (r_index >= r_length) begin
                    o_result.has_result = 1'b1;
                    o_result.code = (i_data == r_crc) ? crc8lfc_pkg::VERDICT_OK
                                                      : crc8lfc_pkg::VERDICT_CRC;
                end else begin
                    n_crc   = crc_out;
                    n_index = r_index + 16'd1;
                end
                // Go idle after the verdict until the next frame start
                if (o_result.has_result) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_index  <= 16'd0;
        end else if (i_step) begin
            r_active <= n_active;
            r_index  <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_length     <= n_length;
            r_crc        <= n_crc;
            r_crc_first  <= n_crc_first;
            r_crc_second <= n_crc_second;
            r_byte0      <= n_byte0;
            r_byte1      <= n_byte1;
        end
    end

endmodule

// File: sv/crc8lfc_out_reg.sv
// Result register of the length-framed checker; holds one verdict until taken.
// Uses crc8lfc_pkg for the verdict request type.
module crc8lfc_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  crc8lfc_pkg::t_result i_result,
    input  logic                 i_ready,
    output logic                 o_space,
    output logic                 o_valid,
    output logic                 o_frame_ok,
    output logic [1:0]           o_code
);

    logic                  r_valid;
    crc8lfc_pkg::t_verdict r_code;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= i_result.code;
        end
    end

    assign o_valid    = r_valid;
    assign o_code     = r_code;
    assign o_frame_ok = (r_code == crc8lfc_pkg::VERDICT_OK);

endmodule

// File: sv/crc8_length_framed_checker.sv
// Top level of the CRC-8 length-framed checker (poly 0x31, init 0, MSB first).
// Uses crc8lfc_pkg, crc8lfc_in_reg, crc8lfc_frame_ctrl and crc8lfc_out_reg.
//
//  port group   dir  payload                         accepted when
//  s_axis_*     in   tdata: data_byte; tuser: start  s_axis_tvalid & s_axis_tready
//  m_axis_*     out  tdata: frame_ok; tuser: verdict m_axis_tvalid & m_axis_tready
//  i_cfg_*      in   i_cfg_data: max_frame_length    i_cfg_valid & o_cfg_ready
//
// One byte per cycle while no verdict is held back: a byte waits in the input register,
// and the CRC update and verdict logic write the result register when the byte steps on.
// A verdict passes from the input register through the result register to m_axis.
// Synchronous active-low reset idles the checker and sets the maximum to 2370.
// A held verdict stalls only bytes that produce a verdict; other bytes flow on.
module crc8_length_framed_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] frame_ok, [7:1] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] verdict_code
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data      // [15:0] max_frame_length
);

    logic                 in_valid;
    logic [7:0]           in_data;
    logic                 in_start;
    logic                 step;
    logic                 out_space;
    logic                 frame_ok;
    logic [15:0]          r_max_len;
    crc8lfc_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= crc8lfc_pkg::MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    // Advance the held byte unless its verdict has nowhere to go
    assign step = in_valid && (!result.has_result || out_space);

    crc8lfc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_start   (s_axis_tuser[0]),
        .i_consume (step),
        .o_valid   (in_valid),
        .o_data    (in_data),
        .o_start   (in_start)
    );

    crc8lfc_frame_ctrl u_frame_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_valid),
        .i_data    (in_data),
        .i_start   (in_start),
        .i_step    (step),
        .i_max_len (r_max_len),
        .o_result  (result)
    );

    crc8lfc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && result.has_result),
        .i_result   (result),
        .i_ready    (m_axis_tready),
        .o_space    (out_space),
        .o_valid    (m_axis_tvalid),
        .o_frame_ok (frame_ok),
        .o_code     (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, frame_ok};

endmodule

// File: tb/tb_top.sv
// Self-checking bench for crc8_length_framed_checker: random and directed frames,
// a per-byte predictor of the verdicts, source gaps and random sink back-pressure.
// Depends on crc8lfc_pkg and the checker RTL.
module tb_top;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_byte_item;

    typedef struct {
        logic                  ok;
        crc8lfc_pkg::t_verdict code;
    } t_verdict_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser = 1'b0;    // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [0] frame_ok, [7:1] zero
    logic [1:0]  m_axis_tuser;           // [1:0] verdict_code
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'h0000;  // [15:0] max_frame_length

    crc8_length_framed_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_byte_item    byte_q[$];
    t_verdict_item verdict_q[$];
    int unsigned n_sent = 0;
    int unsigned n_errors = 0;
    bit          byte_taken = 1'b0;
    bit          idle_en = 1'b1;
    int unsigned src_gap = 0;
    int unsigned src_quiet = 0;
    int unsigned snk_gap = 0;
    int unsigned snk_quiet = 0;

    // Predictor state
    logic [15:0] m_max;
    logic [15:0] m_idx;
    logic [15:0] m_len;
    logic [7:0]  m_crc;
    logic [7:0]  m_crc0;
    logic [7:0]  m_crc1;
    logic [7:0]  m_b0;
    logic [7:0]  m_b1;
    logic        m_busy;

    // Non-reflected CRC-8: fold the byte into the top, then shift out eight bits
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ crc8lfc_pkg::CRC_POLY)
                            : {r[6:0], 1'b0};
        return r;
    endfunction

    function automatic int unsigned draw_gap(inout int unsigned quiet);
        if (quiet != 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 63) == 0) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    endfunction

    task automatic report_miss(input string what, input logic [7:0] want, input logic [7:0] got);
        if (n_errors < 10) begin
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        end
        n_errors++;
    endtask

    task automatic post_verdict(input crc8lfc_pkg::t_verdict code);
        t_verdict_item v;
        v.ok = (code == crc8lfc_pkg::VERDICT_OK);
        v.code = code;
        verdict_q.push_back(v);
        m_busy = 1'b0;
    endtask

    task automatic track_byte(input logic [7:0] b, input logic st);
        if (st) begin
            m_b0 = b;
            m_crc0 = crc8_next(8'h00, b);
            m_crc = m_crc0;
            m_idx = 16'd1;
            m_len = 16'd0;
            m_busy = 1'b1;
        end else if (m_busy) begin
            if (m_idx == 16'd1) begin
                m_b1 = b;
                m_crc1 = crc8_next(m_crc0, b);
                m_crc = m_crc1;
                m_idx = 16'd2;
            end else if (m_idx == 16'd2) begin
                m_len = {m_b1, b};
                // short lengths are settled from the stored early bytes
                if (m_len > m_max) begin
                    post_verdict(crc8lfc_pkg::VERDICT_LONG);
                end else if (m_len == 16'd0) begin
                    post_verdict((m_b0 == 8'h00) ? crc8lfc_pkg::VERDICT_OK
                                                 : crc8lfc_pkg::VERDICT_CRC);
                end else if (m_len == 16'd1) begin
                    post_verdict((m_b1 == m_crc0) ? crc8lfc_pkg::VERDICT_OK
                                                  : crc8lfc_pkg::VERDICT_CRC);
                end else if (m_len == 16'd2) begin
                    post_verdict((b == m_crc1) ? crc8lfc_pkg::VERDICT_OK
                                               : crc8lfc_pkg::VERDICT_CRC);
                end else begin
                    m_crc = crc8_next(m_crc1, b);
                    m_idx = 16'd3;
                end
            end else if (m_idx >= m_len) begin
                post_verdict((b == m_crc) ? crc8lfc_pkg::VERDICT_OK
                                          : crc8lfc_pkg::VERDICT_CRC);
            end else begin
                m_crc = crc8_next(m_crc, b);
                m_idx = m_idx + 16'd1;
            end
        end
    endtask

    // Scoreboard and predictor, sampled at the rising edge
    always @(posedge i_clk) begin
        t_verdict_item want;
        if (!i_rst_n) begin
            byte_taken = 1'b0;
            m_max = crc8lfc_pkg::MAX_LEN_RESET;
            m_idx = 16'd0;
            m_len = 16'd0;
            m_crc = 8'h00;
            m_crc0 = 8'h00;
            m_crc1 = 8'h00;
            m_b0 = 8'h00;
            m_b1 = 8'h00;
            m_busy = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    report_miss("verdict with none pending", 8'h00, {6'd0, m_axis_tuser});
                end else begin
                    want = verdict_q.pop_front();
                    if (m_axis_tdata !== {7'd0, want.ok}) begin
                        report_miss("frame_ok", {7'd0, want.ok}, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.code) begin
                        report_miss("verdict_code", {6'd0, want.code}, {6'd0, m_axis_tuser});
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                m_max = i_cfg_data;
            end
            byte_taken = s_axis_tvalid && s_axis_tready;
            if (byte_taken) begin
                track_byte(s_axis_tdata, s_axis_tuser[0]);
            end
        end
    end

    // Byte driver: advance on acceptance, insert gaps only between requests
    always @(negedge i_clk) begin
        t_byte_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || byte_taken) begin
            if (src_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                src_gap--;
            end else if (byte_q.size() != 0) begin
                nxt = byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= nxt.data;
                s_axis_tuser <= nxt.start;
                if (idle_en) begin
                    src_gap = draw_gap(src_quiet);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Verdict sink with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (snk_gap != 0) begin
            m_axis_tready <= 1'b0;
            snk_gap--;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_en) begin
                snk_gap = draw_gap(snk_quiet);
            end
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic st, input bit counted);
        t_byte_item it;
        it.data = d;
        it.start = st;
        byte_q.push_back(it);
        if (counted) begin
            n_sent++;
        end
    endtask

    // Build one frame; cut != 0 truncates it so the next start drops it
    task automatic push_frame(input logic [15:0] len, input logic [15:0] lim,
                              input bit bad_crc, input int unsigned cut);
        logic [7:0]  fb[$];
        logic [7:0]  acc;
        int unsigned n;
        fb.push_back(8'($urandom_range(0, 255)));
        fb.push_back(len[15:8]);
        fb.push_back(len[7:0]);
        if (len <= lim && len >= 16'd3) begin
            for (int i = 3; i < len; i++) begin
                fb.push_back(8'($urandom_range(0, 255)));
            end
            acc = 8'h00;
            foreach (fb[i]) begin
                acc = crc8_next(acc, fb[i]);
            end
            if (bad_crc) begin
                acc = acc ^ 8'($urandom_range(1, 255));
            end
            fb.push_back(acc);
        end
        n = (cut != 0 && cut < fb.size()) ? cut : fb.size();
        for (int i = 0; i < n; i++) begin
            push_byte(fb[i], (i == 0), 1'b1);
        end
    endtask

    task automatic random_phase(input logic [15:0] lim, input int unsigned budget);
        int unsigned goal;
        int unsigned r;
        int unsigned cut;
        logic [15:0] len;
        goal = n_sent + budget;
        while (n_sent < goal) begin
            r = $urandom_range(0, 99);
            if (lim < 16'd3) begin
                len = (r < 50) ? 16'($urandom_range(0, lim))
                               : 16'($urandom_range(32'(lim) + 1, 65535));
            end else if (r < 6) begin
                len = 16'($urandom_range(0, 2));
            end else if (r < 14 && lim != 16'hFFFF) begin
                len = 16'($urandom_range(32'(lim) + 1, 65535));
            end else if (r < 19) begin
                len = 16'($urandom_range(3, (lim > 16'd200) ? 200 : lim));
            end else begin
                len = 16'($urandom_range(3, (lim > 16'd40) ? 40 : lim));
            end
            cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 6) : 0;
            push_frame(len, lim, ($urandom_range(0, 4) == 0), cut);
            if (cut == 0 && $urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
        end
        // close with a complete short frame so the checker ends idle
        push_frame(16'd0, lim, 1'b0, 0);
    endtask

    // Hold until every queued byte is in and every verdict is out
    task automatic settle();
        while (byte_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_max(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [7:0]  l2_seed;
        logic [15:0] lim_plan[5];
        int unsigned budget[5];
        l2_seed = 8'h00;
        for (int v = 0; v < 256; v++) begin
            if (crc8_next(crc8_next(8'h00, 8'(v)), 8'h00) == 8'h02) begin
                l2_seed = 8'(v);
            end
        end
        lim_plan = '{16'hFFFF, 16'h0000, 16'($urandom_range(3, 60)),
                     crc8lfc_pkg::MAX_LEN_RESET, 16'($urandom_range(100, 400))};
        budget = '{400, 250, 400, 400, 400};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // short lengths, passing and failing, at the reset maximum
        push_byte(8'h00, 1'b1, 1'b1); push_byte(8'h00, 1'b0, 1'b1); push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hA5, 1'b1, 1'b1); push_byte(8'h00, 1'b0, 1'b1); push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'h00, 1'b1, 1'b1); push_byte(8'h00, 1'b0, 1'b1); push_byte(8'h01, 1'b0, 1'b1);
        push_byte(8'h3C, 1'b1, 1'b1); push_byte(8'h00, 1'b0, 1'b1); push_byte(8'h01, 1'b0, 1'b1);
        push_byte(l2_seed, 1'b1, 1'b1); push_byte(8'h00, 1'b0, 1'b1); push_byte(8'h02, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1); push_byte(8'h00, 1'b0, 1'b1); push_byte(8'h02, 1'b0, 1'b1);
        // idle byte, then a frame restarted mid-way by an over-long one
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'h12, 1'b1, 1'b1); push_byte(8'h34, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1); push_byte(8'hFF, 1'b0, 1'b1); push_byte(8'hFF, 1'b0, 1'b1);
        settle();

        // length at the maximum passes, one above is rejected
        write_max(16'd10);
        push_frame(16'd10, 16'd10, 1'b0, 0);
        push_frame(16'd11, 16'd10, 1'b0, 0);
        settle();

        for (int p = 0; p < 5; p++) begin
            if (p == 4) begin
                idle_en = 1'b0;
            end
            write_max(lim_plan[p]);
            random_phase(lim_plan[p], budget[p]);
            settle();
        end

        if (verdict_q.size() != 0) begin
            report_miss("verdicts never delivered", 8'h00, 8'(verdict_q.size()));
        end
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
